// ===== hdl/sise_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted integer set engine package
// Shared widths, request codes and defaults.
// ----------------------------------------------------------------------------
package sise_pkg;

  localparam int unsigned DefCapacity = 16;
  localparam int unsigned MaxResults  = 32;
  localparam int unsigned DataW       = 32;

  typedef enum logic [2:0] {
    REQ_INSERT = 3'd0,
    REQ_ERASE  = 3'd1,
    REQ_FIND   = 3'd2,
    REQ_LIST   = 3'd3,
    REQ_UNION  = 3'd4,
    REQ_INTER  = 3'd5,
    REQ_DIFF   = 3'd6,
    REQ_NONE   = 3'd7
  } req_type_e;

endpackage

// ===== hdl/sise_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sise_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== hdl/sorted_integer_set_engine.sv =====
// ----------------------------------------------------------------------------
// Sorted integer set engine
// Two bounded ascending sets with insert, erase, find, list and merge streams.
// ----------------------------------------------------------------------------
// Channel | Direction | Handshake          | Payload
// req     | in        | req_valid_i/ready_o| req_type_i, which_set_i, value_i
// rsp     | out       | rsp_valid_o/ready_i| found_o, status_o, element_o,
//         |           |                    | element_valid_o, last_o
//
// Each set lives in a RAM with one registered read port. Find, insert and
// erase scan the set one member at a time (S_SCAN, S_SCANW), and insert and
// erase then move members one at a time (S_MOVE, S_MOVEW). A list visits each
// member through S_SCAN and S_SCANW and a merge through S_MRD, S_MRDW and
// S_MCMP. Reset clears both counts; no clearing pass. A stalled response holds
// the sequencer until it is taken.
module sorted_integer_set_engine #(
  parameter int unsigned Capacity = sise_pkg::DefCapacity
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        req_valid_i,
  output logic        req_ready_o,
  input  logic [2:0]  req_type_i,
  input  logic        which_set_i,
  input  logic signed [31:0] value_i,
  output logic        rsp_valid_o,
  input  logic        rsp_ready_i,
  output logic        found_o,
  output logic        status_o,
  output logic signed [31:0] element_o,
  output logic        element_valid_o,
  output logic        last_o
);

  localparam int unsigned AW = (Capacity > 1) ? $clog2(Capacity) : 1;
  localparam int unsigned CW = $clog2(Capacity + 1);
  localparam int unsigned KW = $clog2(sise_pkg::MaxResults + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_SCANW, S_DECIDE, S_MOVE, S_MOVEW, S_MRD, S_MRDW, S_MCMP,
    S_EMIT, S_RSP
  } state_e;

  state_e state_q;
  logic [2:0] req_q;
  logic sel_q;
  logic signed [31:0] val_q;
  logic [CW-1:0] cnt_a_q, cnt_b_q, i_q, j_q, pos_q;
  logic found_q, gt_seen_q;
  logic [KW-1:0] k_q;
  logic pend_q;
  logic signed [31:0] pend_val_q;
  logic rsp_valid_q, found_oq, status_q, ev_q, last_q;
  logic signed [31:0] elem_q;

  logic we_a, we_b;
  logic [AW-1:0] waddr, raddr_a, raddr_b;
  logic [31:0] wdata, rd_a, rd_b;

  sise_ram #(.Width(32), .Depth(Capacity), .AddrW(AW)) u_ram_a (
    .clk_i, .we_i(we_a), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr_a), .rdata_o(rd_a));
  sise_ram #(.Width(32), .Depth(Capacity), .AddrW(AW)) u_ram_b (
    .clk_i, .we_i(we_b), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr_b), .rdata_o(rd_b));

  logic [CW-1:0] n_sel;
  logic signed [31:0] rd_sel, xa, xb;
  logic [CW-1:0] i_n;
  assign n_sel  = sel_q ? cnt_b_q : cnt_a_q;
  assign rd_sel = sel_q ? rd_b : rd_a;
  assign xa = rd_a;
  assign xb = rd_b;

  // Shared address path: scans read at i_q, moves read at i_q as well.
  logic [CW-1:0] rd_idx;
  always_comb begin
    rd_idx = i_q;
    raddr_a = rd_idx[AW-1:0];
    raddr_b = rd_idx[AW-1:0];
    if (state_q inside {S_MRD, S_MRDW, S_MCMP}) begin
      raddr_a = i_q[AW-1:0];
      raddr_b = j_q[AW-1:0];
    end
  end

  // Merge decision from the a_le_b and b_le_a comparisons.
  logic a_ok, b_ok, take_a, take_b, a_le_b, b_le_a, keep;
  assign a_ok = i_q < cnt_a_q;
  assign b_ok = j_q < cnt_b_q;
  assign a_le_b = xa <= xb;
  assign b_le_a = xb <= xa;
  always_comb begin
    if (a_ok && b_ok) begin
      take_a = a_le_b;
      take_b = b_le_a;
    end else begin
      take_a = a_ok;
      take_b = b_ok;
    end
    case (req_q)
      sise_pkg::REQ_UNION: keep = 1'b1;
      sise_pkg::REQ_INTER: keep = take_a && take_b;
      sise_pkg::REQ_DIFF:  keep = take_a && !take_b;
      default:             keep = 1'b0;
    endcase
  end

  logic wr_en;
  assign we_a = wr_en && !sel_q;
  assign we_b = wr_en && sel_q;

  logic rsp_free;
  assign rsp_free = !rsp_valid_q || rsp_ready_i;
  assign req_ready_o = (state_q == S_IDLE) && !rsp_valid_q;
  assign i_n = i_q + CW'(1);

  // Write path: insert shifts down (from top) then writes val_q at pos_q, erase shifts up.
  always_comb begin
    wr_en = 1'b0;
    waddr = i_q[AW-1:0];
    wdata = rd_sel;
    if (state_q == S_MOVEW) begin
      if (req_q == sise_pkg::REQ_INSERT) begin
        wr_en = 1'b1;
        waddr = i_n[AW-1:0];
      end else begin
        wr_en = 1'b1;
        waddr = AW'(i_q - CW'(1));
      end
    end else if (state_q == S_DECIDE && req_q == sise_pkg::REQ_INSERT && !found_q
                 && n_sel < CW'(Capacity) && i_q == pos_q) begin
      wr_en = 1'b1;
      waddr = pos_q[AW-1:0];
      wdata = val_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_a_q <= '0;
      cnt_b_q <= '0;
      rsp_valid_q <= 1'b0;
      req_q <= '0; sel_q <= 1'b0; val_q <= '0;
      i_q <= '0; j_q <= '0; pos_q <= '0; found_q <= 1'b0; gt_seen_q <= 1'b0;
      k_q <= '0; pend_q <= 1'b0; pend_val_q <= '0;
      found_oq <= 1'b0; status_q <= 1'b0; ev_q <= 1'b0; last_q <= 1'b0;
      elem_q <= '0;
    end else begin
      if (rsp_valid_q && rsp_ready_i) rsp_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (req_valid_i && req_ready_o) begin
            req_q <= req_type_i; sel_q <= which_set_i; val_q <= value_i;
            i_q <= '0; j_q <= '0; found_q <= 1'b0; gt_seen_q <= 1'b0;
            k_q <= '0; pend_q <= 1'b0;
            pos_q <= which_set_i ? cnt_b_q : cnt_a_q;
            case (req_type_i)
              sise_pkg::REQ_INSERT, sise_pkg::REQ_ERASE, sise_pkg::REQ_FIND,
              sise_pkg::REQ_LIST: state_q <= S_SCAN;
              sise_pkg::REQ_UNION, sise_pkg::REQ_INTER,
              sise_pkg::REQ_DIFF: state_q <= S_MRD;
              default: begin
                found_oq <= 1'b0; status_q <= 1'b0; ev_q <= 1'b0;
                elem_q <= '0; last_q <= 1'b1;
                state_q <= S_RSP;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (i_q >= n_sel) begin
            if (req_q == sise_pkg::REQ_LIST) begin
              state_q <= S_EMIT;
            end else begin
              state_q <= S_DECIDE;
            end
          end else begin
            state_q <= S_SCANW;
          end
        end
        S_SCANW: begin
          if (req_q == sise_pkg::REQ_LIST) begin
            if (k_q < KW'(sise_pkg::MaxResults)) begin
              if (!pend_q) begin
                pend_q <= 1'b1; pend_val_q <= rd_sel;
                k_q <= k_q + KW'(1);
                i_q <= i_n; state_q <= S_SCAN;
              end else if (rsp_free) begin
                found_oq <= 1'b0; status_q <= 1'b0; ev_q <= 1'b1;
                elem_q <= pend_val_q; last_q <= 1'b0;
                rsp_valid_q <= 1'b1; k_q <= k_q + KW'(1);
                pend_val_q <= rd_sel;
                i_q <= i_n; state_q <= S_SCAN;
              end
            end else begin
              i_q <= i_n; state_q <= S_SCAN;
            end
          end else begin
            if (rd_sel == val_q && !found_q) begin
              found_q <= 1'b1; pos_q <= i_q;
            end
            if (!gt_seen_q && !found_q && rd_sel > val_q) begin
              gt_seen_q <= 1'b1; pos_q <= i_q;
            end
            i_q <= i_n; state_q <= S_SCAN;
          end
        end
        S_DECIDE: begin
          found_oq <= found_q; status_q <= 1'b0; ev_q <= 1'b0;
          elem_q <= '0; last_q <= 1'b1;
          if (req_q == sise_pkg::REQ_INSERT && !found_q) begin
            if (n_sel >= CW'(Capacity)) begin
              status_q <= 1'b1; state_q <= S_RSP;
            end else if (i_q == pos_q) begin
              if (sel_q) cnt_b_q <= cnt_b_q + CW'(1);
              else cnt_a_q <= cnt_a_q + CW'(1);
              state_q <= S_RSP;
            end else begin
              i_q <= i_q - CW'(1); state_q <= S_MOVE;
            end
          end else if (req_q == sise_pkg::REQ_ERASE && found_q) begin
            i_q <= pos_q + CW'(1); state_q <= S_MOVE;
          end else begin
            state_q <= S_RSP;
          end
        end
        S_MOVE: begin
          if (req_q == sise_pkg::REQ_ERASE && i_q >= n_sel) begin
            if (sel_q) cnt_b_q <= cnt_b_q - CW'(1);
            else cnt_a_q <= cnt_a_q - CW'(1);
            state_q <= S_RSP;
          end else begin
            state_q <= S_MOVEW;
          end
        end
        S_MOVEW: begin
          if (req_q == sise_pkg::REQ_INSERT) begin
            if (i_q == pos_q) begin
              i_q <= pos_q; state_q <= S_DECIDE;
            end else begin
              i_q <= i_q - CW'(1); state_q <= S_MOVE;
            end
          end else begin
            i_q <= i_n; state_q <= S_MOVE;
          end
        end
        S_MRD: begin
          if (!a_ok && !b_ok) state_q <= S_EMIT;
          else state_q <= S_MRDW;
        end
        S_MRDW: state_q <= S_MCMP;
        S_MCMP: begin
          if (keep && k_q < KW'(sise_pkg::MaxResults)) begin
            if (pend_q) begin
              if (rsp_free) begin
                found_oq <= 1'b0; status_q <= 1'b0; ev_q <= 1'b1;
                elem_q <= pend_val_q; last_q <= 1'b0; rsp_valid_q <= 1'b1;
                pend_val_q <= take_a ? xa : xb;
                k_q <= k_q + KW'(1);
                if (take_a) i_q <= i_n;
                if (take_b) j_q <= j_q + CW'(1);
                state_q <= S_MRD;
              end
            end else begin
              pend_q <= 1'b1; pend_val_q <= take_a ? xa : xb;
              k_q <= k_q + KW'(1);
              if (take_a) i_q <= i_n;
              if (take_b) j_q <= j_q + CW'(1);
              state_q <= S_MRD;
            end
          end else begin
            if (take_a) i_q <= i_n;
            if (take_b) j_q <= j_q + CW'(1);
            state_q <= S_MRD;
          end
        end
        S_EMIT: begin
          if (rsp_free) begin
            found_oq <= 1'b0; status_q <= 1'b0; ev_q <= pend_q;
            elem_q <= pend_q ? pend_val_q : '0; last_q <= 1'b1;
            rsp_valid_q <= 1'b1; state_q <= S_IDLE;
          end
        end
        S_RSP: begin
          if (rsp_free) begin
            rsp_valid_q <= 1'b1; state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign rsp_valid_o     = rsp_valid_q;
  assign found_o         = found_oq;
  assign status_o        = status_q;
  assign element_o       = elem_q;
  assign element_valid_o = ev_q;
  assign last_o          = last_q;

endmodule

// ===== hdl/sise_checker.sv =====
// ----------------------------------------------------------------------------
// Sorted integer set engine checker
// Port-level properties, bound to the top level.
// ----------------------------------------------------------------------------
module sise_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        req_valid_i,
  input logic        req_ready_o,
  input logic        rsp_valid_o,
  input logic        rsp_ready_i,
  input logic        found_o,
  input logic        status_o,
  input logic        element_valid_o,
  input logic        last_o,
  input logic [31:0] element_o
);

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && !rsp_ready_i |=> rsp_valid_o && $stable(element_o))
    else $error("Stalled response changed.");

  a_no_ready_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> !req_ready_o)
    else $error("Request taken while a response is pending.");

  a_status_only_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && status_o |-> last_o && !found_o && !element_valid_o)
    else $error("Dropped insert answer malformed.");

  a_found_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && found_o |-> last_o && !element_valid_o)
    else $error("Found answer malformed.");

endmodule

bind sorted_integer_set_engine sise_checker u_sise_checker (
  .clk_i, .rst_ni, .req_valid_i, .req_ready_o, .rsp_valid_o, .rsp_ready_i,
  .found_o, .status_o, .element_valid_o, .last_o, .element_o
);
